>>> sv/txc_pkg.sv
package txc_pkg;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [8:0]  CODE_NEWLINE   = 9'd10;
  localparam logic [8:0]  CODE_BACKSPACE = 9'h100;
  localparam logic [7:0]  TEXT_ATTR      = 8'h07;
  localparam logic [15:0] BLANK_CELL     = 16'h0720;

  typedef struct packed {
    logic       op;
    logic [8:0] char_code;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        scrolled;
    logic [15:0] cell_data;
  } rsp_t;

endpackage

>>> sv/text_console_cursor_scroll_unit.sv
// Text console writer holding a COLUMNS x ROWS screen of 16-bit cells in one
// single-port-write memory. After reset the block clears the screen, one cell
// a cycle, and stays busy until all COLUMNS*ROWS cells (1920 by default) are
// cleared. A read request passes through S_READ, which registers its result;
// a put passes through S_PUT and S_BLANK. A put that scrolls walks the screen
// memory through its one write port in S_COPY, S_DRAIN and S_ZERO. The result
// is shown on result for the single cycle in which done is high and cannot be
// held off; the next request may be accepted in that same cycle.
module text_console_cursor_scroll_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  txc_pkg::req_t request,
  output logic          done,
  output txc_pkg::rsp_t result
);
  import txc_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int IW    = (AW > 11) ? AW : 11;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_PUT, S_COPY, S_DRAIN, S_ZERO, S_BLANK
  } state_t;

  state_t          state;
  req_t            req_q;
  logic [AW-1:0]   cursor;
  logic [CW-1:0]   col;
  logic [AW-1:0]   addr;
  logic [AW-1:0]   addr_q;
  logic            copy_pend;
  logic            in_range_q;
  logic            scrolled;
  logic [15:0]     rd_data;
  logic [15:0]     screen [CELLS];

  logic            we;
  logic [AW-1:0]   waddr;
  logic [15:0]     wdata;
  logic [AW-1:0]   raddr;
  logic [IW-1:0]   idx_ext;
  logic            in_range;
  logic            is_newline;
  logic            is_backspace;
  logic [PW-1:0]   pos_next;
  logic [CW-1:0]   col_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    idx_ext      = IW'(request.cell_index);
    in_range     = idx_ext < IW'(CELLS);
    is_newline   = (req_q.char_code == CODE_NEWLINE);
    is_backspace = (req_q.char_code == CODE_BACKSPACE);
    raddr        = (state == S_IDLE) ? idx_ext[AW-1:0] : addr;
  end

  always_comb begin
    pos_next = PW'(cursor);
    col_next = col;
    if (is_newline) begin
      pos_next = PW'(cursor) + PW'(COLUMNS) - PW'(col);
      col_next = '0;
    end else if (is_backspace) begin
      if (cursor != '0) begin
        pos_next = PW'(cursor) - PW'(1);
        col_next = (col == '0) ? LAST_COL : col - CW'(1);
      end
    end else begin
      pos_next = PW'(cursor) + PW'(1);
      col_next = (col == LAST_COL) ? '0 : col + CW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (copy_pend) begin
      we    = 1'b1;
      waddr = addr_q - ROW_STEP;
      wdata = rd_data;
    end else begin
      case (state)
        S_CLEAR, S_ZERO: begin
          we = 1'b1;
        end
        S_PUT: begin
          waddr = cursor;
          wdata = {TEXT_ATTR, req_q.char_code[7:0]};
          we    = !is_newline && !is_backspace;
        end
        S_BLANK: begin
          we    = 1'b1;
          waddr = cursor;
          wdata = BLANK_CELL;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      screen[waddr] <= wdata;
    end
    rd_data <= screen[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      cursor    <= '0;
      col       <= '0;
      copy_pend <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= 1'b0;
      copy_pend <= (state == S_COPY);
      addr_q    <= addr;
      case (state)
        S_CLEAR: begin
          if (addr == LAST_CELL) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q      <= request;
            in_range_q <= in_range;
            scrolled   <= 1'b0;
            state      <= (request.op == OP_READ) ? S_READ : S_PUT;
          end
        end
        S_READ: begin
          result.cursor_pos <= 11'(cursor);
          result.scrolled   <= 1'b0;
          result.cell_data  <= in_range_q ? rd_data : '0;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_PUT: begin
          if (pos_next == PW'(CELLS)) begin
            cursor   <= LAST_ROW;
            col      <= '0;
            scrolled <= 1'b1;
            addr     <= ROW_STEP;
            state    <= S_COPY;
          end else begin
            cursor <= pos_next[AW-1:0];
            col    <= col_next;
            state  <= S_BLANK;
          end
        end
        S_COPY: begin
          if (addr == LAST_CELL) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_DRAIN: begin
          addr  <= LAST_ROW;
          state <= S_ZERO;
        end
        S_ZERO: begin
          if (addr == LAST_CELL) begin
            state <= S_BLANK;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_BLANK: begin
          result.cursor_pos <= 11'(cursor);
          result.scrolled   <= scrolled;
          result.cell_data  <= '0;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/txc_checker.sv
module txc_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input txc_pkg::rsp_t result
);
  import txc_pkg::*;

  localparam logic [10:0] LAST_ROW_POS = 11'((ROWS - 1) * COLUMNS);

  // Every accepted request makes the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without the block turning busy");

  // A result only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // Results never come in consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |-> (result.cursor_pos == LAST_ROW_POS))
    else $error("cursor not on the bottom row after a scroll");

  // A scroll never reports cell data.
  a_scroll_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |-> (result.cell_data == 16'h0000))
    else $error("cell data reported for a put");

endmodule

bind text_console_cursor_scroll_unit txc_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_txc_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .result(result)
);

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import txc_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 24;
  localparam int CELLS = COLS * ROWS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  logic [15:0] shadow_screen [CELLS];
  int shadow_cursor = 0;
  rsp_t console_replies_due [$];
  int mismatches = 0;
  int idle_pct = 0;

  text_console_cursor_scroll_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t tb: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one request to the shadow screen and returns the reply it should produce.
  function automatic rsp_t apply_console_request(req_t r);
    rsp_t reply;
    int pos;
    reply = '0;
    if (r.op == OP_PUT) begin
      pos = shadow_cursor;
      if (r.char_code == CODE_NEWLINE) begin
        pos += COLS - (pos % COLS);
      end else if (r.char_code == CODE_BACKSPACE) begin
        if (pos > 0) pos--;
      end else begin
        shadow_screen[pos] = {TEXT_ATTR, r.char_code[7:0]};
        pos++;
      end
      if (pos / COLS >= ROWS) begin
        for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
        pos -= COLS;
        for (int i = pos; i < CELLS; i++) shadow_screen[i] = '0;
        reply.scrolled = 1'b1;
      end
      shadow_cursor = pos;
      shadow_screen[pos] = BLANK_CELL;
    end else if (r.cell_index < CELLS) begin
      reply.cell_data = shadow_screen[r.cell_index];
    end
    reply.cursor_pos = shadow_cursor[10:0];
    return reply;
  endfunction

  function automatic req_t make_req(logic op, int code, int index);
    req_t r;
    r.op = op;
    r.char_code = code[8:0];
    r.cell_index = index[10:0];
    return r;
  endfunction

  // Mostly printable text with newlines and backspaces, so the screen fills and scrolls;
  // reads favour the cells around the cursor.
  function automatic req_t random_request();
    req_t r;
    int pick;
    int lo;
    int hi;
    r.op = ($urandom_range(0, 99) < 35) ? OP_READ : OP_PUT;
    r.char_code = 9'($urandom_range(0, 511));
    r.cell_index = 11'($urandom_range(0, 2047));
    if (r.op == OP_PUT) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) r.char_code = CODE_NEWLINE;
      else if (pick < 12) r.char_code = CODE_BACKSPACE;
      else if (pick < 87) r.char_code = 9'($urandom_range(32, 126));
    end else if ($urandom_range(0, 1) == 1) begin
      lo = (shadow_cursor > 160) ? shadow_cursor - 160 : 0;
      hi = (shadow_cursor + 80 < 2047) ? shadow_cursor + 80 : 2047;
      r.cell_index = 11'($urandom_range(hi, lo));
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    console_replies_due.push_back(apply_console_request(r));
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (console_replies_due.size() == 0) begin
        report_mismatch("unexpected result", int'(result), 0);
      end else begin
        want = console_replies_due.pop_front();
        if (result.cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", int'(result.cursor_pos), int'(want.cursor_pos));
        if (result.scrolled !== want.scrolled)
          report_mismatch("scrolled", int'(result.scrolled), int'(want.scrolled));
        if (result.cell_data !== want.cell_data)
          report_mismatch("cell_data", int'(result.cell_data), int'(want.cell_data));
      end
    end
  end

  task automatic test_reset_screen();
    send_request(make_req(OP_READ, 9'h1FF, 0));
    send_request(make_req(OP_READ, 0, CELLS - 1));
    send_request(make_req(OP_READ, CODE_NEWLINE, CELLS));
    send_request(make_req(OP_READ, CODE_BACKSPACE, 2047));
  endtask

  task automatic test_backspace_at_origin();
    send_request(make_req(OP_PUT, CODE_BACKSPACE, 2047));
    send_request(make_req(OP_READ, 0, 0));
  endtask

  task automatic test_put_codes();
    send_request(make_req(OP_PUT, 0, 0));
    send_request(make_req(OP_PUT, 255, 1919));
    send_request(make_req(OP_PUT, 266, 2047));
    send_request(make_req(OP_PUT, 511, 1024));
    send_request(make_req(OP_PUT, 65, 5));
    send_request(make_req(OP_PUT, CODE_NEWLINE, 2047));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(OP_READ, 0, 2));
    send_request(make_req(OP_READ, 9'h1FF, 3));
    send_request(make_req(OP_READ, 0, 5));
    send_request(make_req(OP_READ, CODE_NEWLINE, 80));
  endtask

  task automatic test_backspace_wrap();
    send_request(make_req(OP_PUT, CODE_BACKSPACE, 0));
    send_request(make_req(OP_READ, 0, 79));
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_screen();
    test_backspace_at_origin();
    test_put_codes();
    test_backspace_wrap();
    test_random(300, 0);
    test_random(300, 66);
    test_random(300, 6);
    test_random(250, 0);
    start <= 1'b0;
    while (console_replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
